// File: rtl/srd_pkg.sv
// package for the sprite rle row decoder
// holds the decode phase type, field widths and the result record; no dependencies
`timescale 1ns / 1ps

package srd_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int BYTE_W    = 8;

    localparam logic [BYTE_W-1:0] ROW_DELIM = 8'hFF;

    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_COUNT = 2'd1,
        PH_RUN   = 2'd2
    } phase_t;

    typedef struct packed {
        logic              pixel_valid;
        logic [COL_W-1:0]  column;
        logic [BYTE_W-1:0] pixel_value;
        logic              row_end;
        logic              row_error;
    } result_t;

endpackage

// File: rtl/sprite_rle_row_decoder.sv
// top level of the sprite rle row decoder: input register, decode step, result register
// depends on srd_pkg
`timescale 1ns / 1ps

// Decodes one sprite row from a stream of encoded bytes, one byte per request.
// A row is a series of pairs: a skip count (transparent pixels, never written),
// an opaque count, then that many palette bytes. 0xFF where a skip count is
// expected ends the row. Every opaque byte whose column is below row_width
// gives one result with pixel_valid set; bytes past the width are consumed and
// dropped. A request with row_last set ends the row: the result carries
// row_end, and row_error when the row stopped after a lone skip count or with
// opaque bytes still owed. Requests that neither write a pixel nor end the row
// give no result. After a row end the decoder starts a fresh row at column 0.
// Flow: a request goes into an input register, is decoded from there, and its
// result is registered in the output register; a blocked output register holds
// the byte in the input register. One request is taken every cycle as long as
// the output register is empty or being drained; the single decode stage with
// its column/run state is the only loop. row_width is to be written with
// cfg_write/cfg_data only while the decoder is idle; the block does not enforce
// this. Reset value of row_width is 64.
module sprite_rle_row_decoder
    import srd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // configuration
    input  logic              cfg_write,
    input  logic [COL_W-1:0]  cfg_data,

    // encoded byte requests
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              row_last,

    // pixel write / row end results
    output logic              out_valid,
    input  logic              out_ready,
    output logic              pixel_valid,
    output logic [COL_W-1:0]  column,
    output logic [BYTE_W-1:0] pixel_value,
    output logic              row_end,
    output logic              row_error
);

    localparam logic [COL_W-1:0] WIDTH_RESET = COL_W'(64);

    // configuration register
    logic [COL_W-1:0]  width_reg;

    // input register
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;

    // row state
    phase_t            phase_reg, phase_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [BYTE_W-1:0] run_reg, run_next;

    // output register
    logic              out_valid_reg;
    result_t           res_reg, res_next;
    logic              has_result;

    logic              s1_advance;
    logic              s1_fire;
    logic [COL_W:0]    skip_sum;
    logic [BYTE_W-1:0] run_dec;
    logic              end_row;

    // decode stage moves whenever the output slot can take a result
    assign s1_advance = !out_valid_reg || out_ready;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign in_ready   = !s1_valid_reg || s1_advance;

    assign skip_sum = {1'b0, col_reg} + {{(COL_W+1-BYTE_W){1'b0}}, s1_byte_reg};
    assign run_dec  = run_reg - BYTE_W'(1);

    // one decode step on the registered byte
    always_comb
    begin
        phase_next = phase_reg;
        col_next   = col_reg;
        run_next   = run_reg;
        res_next   = '0;
        end_row    = 1'b0;
        unique case (phase_reg)
            PH_COUNT:
            begin
                run_next   = s1_byte_reg;
                phase_next = (s1_byte_reg == '0) ? PH_SKIP : PH_RUN;
                if (s1_last_reg)
                begin
                    end_row            = 1'b1;
                    res_next.row_error = (s1_byte_reg != '0);
                end
            end
            PH_RUN:
            begin
                if (col_reg < width_reg)
                begin
                    res_next.pixel_valid = 1'b1;
                    res_next.column      = col_reg;
                    res_next.pixel_value = s1_byte_reg;
                    col_next             = col_reg + COL_W'(1);
                end
                run_next = run_dec;
                if (run_dec == '0)
                begin
                    phase_next = PH_SKIP;
                end
                if (s1_last_reg)
                begin
                    end_row            = 1'b1;
                    res_next.row_error = (run_dec != '0);
                end
            end
            default:
            begin
                // skip count, also the unused phase code
                if (s1_byte_reg == ROW_DELIM)
                begin
                    end_row = 1'b1;
                end
                else
                begin
                    col_next   = (skip_sum > {1'b0, width_reg}) ? width_reg
                                                                : skip_sum[COL_W-1:0];
                    phase_next = PH_COUNT;
                    if (s1_last_reg)
                    begin
                        end_row            = 1'b1;
                        res_next.row_error = 1'b1;
                    end
                end
            end
        endcase
        res_next.row_end = end_row;
        // row end brings the row state back to its start
        if (end_row)
        begin
            phase_next = PH_SKIP;
            col_next   = '0;
            run_next   = '0;
        end
    end

    assign has_result = res_next.pixel_valid || res_next.row_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            width_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= row_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            col_reg   <= '0;
            run_reg   <= '0;
        end
        else if (s1_fire)
        begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            run_reg   <= run_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && has_result)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_valid = res_reg.pixel_valid;
    assign column      = res_reg.column;
    assign pixel_value = res_reg.pixel_value;
    assign row_end     = res_reg.row_end;
    assign row_error   = res_reg.row_error;

    // a shown result is never empty
    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_valid || row_end))
        else $error("empty result shown");

    // an error only comes with a row end
    a_error_with_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && row_error) |-> row_end)
        else $error("row_error without row_end");

    // a decoded row end leaves the row state cleared
    a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && end_row) |=> (phase_reg == PH_SKIP && col_reg == '0 && run_reg == '0))
        else $error("row state not cleared after row end");

    // backpressure only when the input register holds a waiting byte
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");

    // a stalled byte in the input register does not touch the row state
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> ($stable(col_reg) && $stable(run_reg) && $stable(phase_reg)))
        else $error("row state moved without a decode step");

endmodule

// File: verif/srd_row_checker.sv
// checker for the sprite rle row decoder: tracks row decode state from accepted byte
// requests, queues the expected pixel writes and row ends, compares them with the results
// depends on srd_pkg
`timescale 1ns / 1ps

module srd_row_checker
    import srd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [COL_W-1:0]  cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              row_last,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              pixel_valid,
    input  logic [COL_W-1:0]  column,
    input  logic [BYTE_W-1:0] pixel_value,
    input  logic              row_end,
    input  logic              row_error,
    output int                fail_count,
    output int                pending
);

    // shadow of the decoder state
    logic [COL_W-1:0] width_now;
    phase_t           phase_now;
    logic [COL_W:0]   next_col;
    logic [7:0]       opaque_left;

    result_t results_due[$];
    int      fails = 0;

    always @(posedge clk or negedge rst_n)
    begin : row_model
        result_t      produced;
        result_t      want;
        logic [COL_W:0] col_sum;
        if (!rst_n)
        begin
            width_now   = 12'd64;
            phase_now   = PH_SKIP;
            next_col    = '0;
            opaque_left = '0;
            results_due.delete();
            pending    <= 0;
            fail_count <= fails;
        end
        else
        begin
            if (cfg_write)
                width_now = cfg_data;

            // result side
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result with nothing expected: column %0d value %0d end %0b",
                           column, pixel_value, row_end);
                    fails++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (pixel_valid !== want.pixel_valid)
                    begin
                        $error("pixel_valid: expected %0b, got %0b", want.pixel_valid,
                               pixel_valid);
                        fails++;
                    end
                    if (column !== want.column)
                    begin
                        $error("column: expected %0d, got %0d", want.column, column);
                        fails++;
                    end
                    if (pixel_value !== want.pixel_value)
                    begin
                        $error("pixel_value: expected %0d, got %0d", want.pixel_value,
                               pixel_value);
                        fails++;
                    end
                    if (row_end !== want.row_end)
                    begin
                        $error("row_end: expected %0b, got %0b", want.row_end, row_end);
                        fails++;
                    end
                    if (row_error !== want.row_error)
                    begin
                        $error("row_error: expected %0b, got %0b", want.row_error,
                               row_error);
                        fails++;
                    end
                end
            end

            // request side
            if (in_valid && in_ready)
            begin
                produced = '0;
                case (phase_now)
                    PH_COUNT:
                    begin
                        opaque_left = data_byte;
                        phase_now   = (data_byte == 0) ? PH_SKIP : PH_RUN;
                        if (row_last)
                        begin
                            produced.row_end   = 1'b1;
                            produced.row_error = (data_byte != 0);
                        end
                    end
                    PH_RUN:
                    begin
                        if (next_col < {1'b0, width_now})
                        begin
                            produced.pixel_valid = 1'b1;
                            produced.column      = next_col[COL_W-1:0];
                            produced.pixel_value = data_byte;
                            next_col             = next_col + 1'b1;
                        end
                        opaque_left = opaque_left - 1'b1;
                        if (opaque_left == 0)
                            phase_now = PH_SKIP;
                        if (row_last)
                        begin
                            produced.row_end   = 1'b1;
                            produced.row_error = (opaque_left != 0);
                        end
                    end
                    default:
                    begin
                        if (data_byte == ROW_DELIM)
                            produced.row_end = 1'b1;
                        else
                        begin
                            // skipped columns saturate at the width
                            col_sum   = next_col + data_byte;
                            next_col  = (col_sum > {1'b0, width_now}) ? {1'b0, width_now}
                                                                      : col_sum;
                            phase_now = PH_COUNT;
                            if (row_last)
                            begin
                                produced.row_end   = 1'b1;
                                produced.row_error = 1'b1;
                            end
                        end
                    end
                endcase
                if (produced.row_end)
                begin
                    phase_now   = PH_SKIP;
                    next_col    = '0;
                    opaque_left = '0;
                end
                if (produced.pixel_valid || produced.row_end)
                    results_due = {results_due, produced};
            end

            pending    <= results_due.size();
            fail_count <= fails;
        end
    end

endmodule

// File: verif/tb.sv
// testbench top for the sprite rle row decoder: clock, reset, byte stimulus, result
// back-pressure and the verdict; checking lives in srd_row_checker
// depends on srd_pkg, srd_row_checker and sprite_rle_row_decoder
`timescale 1ns / 1ps

module tb;
    import srd_pkg::*;

    // generous bound on the whole run, in clock cycles
    localparam int CYCLE_LIMIT = 500000;
    // requests in each random phase
    localparam int PHASE_ITEMS = 200;

    // kinds of encoded row the generator can produce
    typedef enum int {
        ROW_DELIMITED,
        ROW_DATA_END,
        ROW_CUT_SKIP,
        ROW_CUT_COUNT,
        ROW_CUT_RUN,
        ROW_NOISE
    } row_kind_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic [COL_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] data_byte;
    logic              row_last;
    logic              out_valid;
    logic              out_ready;
    logic              pixel_valid;
    logic [COL_W-1:0]  column;
    logic [BYTE_W-1:0] pixel_value;
    logic              row_end;
    logic              row_error;

    int fail_count;
    int pending;
    int sent        = 0;
    int cycle_count = 0;
    // set for the closing phase: no gaps, no stalls
    logic quiet = 1'b0;

    sprite_rle_row_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .row_last   (row_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_valid(pixel_valid),
        .column     (column),
        .pixel_value(pixel_value),
        .row_end    (row_end),
        .row_error  (row_error)
    );

    srd_row_checker row_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .row_last   (row_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_valid(pixel_valid),
        .column     (column),
        .pixel_value(pixel_value),
        .row_end    (row_end),
        .row_error  (row_error),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL sprite_rle_row_decoder");
            $finish;
        end
    end

    // result side back-pressure: random stall bursts
    initial
    begin : result_sink
        int hold;
        hold      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 16) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // one byte request; may open with a gap, returns in the step it was taken
    // so the caller drives valid again (or drops it) without time passing
    task automatic send_byte(input logic [7:0] value, input logic last_flag);
        int gap;
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        row_last  <= last_flag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    // stop sending and wait until every pixel write and row end has come back,
    // then give the two-stage pipe time to drain requests that make no result
    task automatic drain_decoder();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_row_width(input logic [COL_W-1:0] width);
        drain_decoder();
        cfg_data  <= width;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // skip counts: mostly short, now and then up to the largest non-delimiter
    function automatic logic [7:0] pick_skip();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 254));
        return 8'($urandom_range(0, 12));
    endfunction

    // opaque counts: mostly short runs, rarely long ones up to 255
    function automatic int pick_count();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 255);
        return $urandom_range(0, 10);
    endfunction

    // build one encoded row of the given kind and send it
    task automatic send_row(input row_kind_t kind);
        logic [7:0] row_bytes[$];
        int         pairs;
        int         n;
        int         k;
        logic       tail_last;
        logic       flag;
        pairs = $urandom_range((kind == ROW_DATA_END) ? 1 : 0, 4);
        for (int p = 0; p < pairs; p++)
        begin
            row_bytes = {row_bytes, pick_skip()};
            n = pick_count();
            row_bytes = {row_bytes, 8'(n)};
            repeat (n) row_bytes = {row_bytes, 8'($urandom_range(0, 255))};
        end
        tail_last = 1'b1;
        case (kind)
            ROW_DELIMITED:
            begin
                row_bytes = {row_bytes, ROW_DELIM};
                tail_last = 1'($urandom_range(0, 1));
            end
            ROW_CUT_SKIP:
                row_bytes = {row_bytes, pick_skip()};
            ROW_CUT_COUNT:
            begin
                row_bytes = {row_bytes, pick_skip()};
                row_bytes = {row_bytes, 8'($urandom_range(1, 255))};
            end
            ROW_CUT_RUN:
            begin
                // stop somewhere inside an opaque run
                row_bytes = {row_bytes, pick_skip()};
                n = $urandom_range(2, 40);
                row_bytes = {row_bytes, 8'(n)};
                k = $urandom_range(1, n - 1);
                repeat (k) row_bytes = {row_bytes, 8'($urandom_range(0, 255))};
            end
            ROW_NOISE:
            begin
                row_bytes.delete();
                repeat ($urandom_range(1, 20))
                    row_bytes = {row_bytes, 8'($urandom_range(0, 255))};
                tail_last = 1'($urandom_range(0, 1));
            end
            default:
                ;
        endcase
        foreach (row_bytes[i])
        begin
            if (i == row_bytes.size() - 1)
                flag = tail_last;
            else
                flag = (kind == ROW_NOISE) && ($urandom_range(0, 7) == 0);
            send_byte(row_bytes[i], flag);
        end
    endtask

    initial
    begin : stimulus
        logic [COL_W-1:0] widths[6];
        row_kind_t        kind;
        int               roll;
        int               goal;

        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        data_byte = '0;
        row_last  = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at the reset width of 64
        // empty row: delimiter straight away
        send_byte(8'hFF, 1'b0);
        // two pixels at the row start, the second one palette 0xFF, then delimiter
        send_byte(8'd0, 1'b0);
        send_byte(8'd2, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(ROW_DELIM, 1'b0);
        // zero opaque count, then a delimiter that is also the last byte
        send_byte(8'd3, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(ROW_DELIM, 1'b1);
        // data runs out after a lone skip count
        send_byte(8'd5, 1'b1);
        // data runs out on a nonzero opaque count
        send_byte(8'd0, 1'b0);
        send_byte(8'd4, 1'b1);
        // data ends on a zero opaque count: clean end
        send_byte(8'd2, 1'b0);
        send_byte(8'd0, 1'b1);
        // data ends inside a run: pixel and error in one result
        send_byte(8'd0, 1'b0);
        send_byte(8'd3, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b1);
        // data ends right as the run completes
        send_byte(8'd0, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'hCC, 1'b1);
        // run with opaque count 0xFF crossing the right edge: last two columns, then dropped
        send_byte(8'd62, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b1);

        // random phases, one row width each; the last one runs without gaps or stalls
        widths = '{12'd1, 12'd4095, 12'd0, 12'd20, 12'd64, 12'd64};
        widths[4] = COL_W'($urandom_range(2, 300));
        for (int ph = 0; ph < 6; ph++)
        begin
            set_row_width(widths[ph]);
            if (ph == 5)
                quiet = 1'b1;
            goal = sent + PHASE_ITEMS;
            while (sent < goal)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    kind = ROW_DELIMITED;
                else if (roll < 70)
                    kind = ROW_DATA_END;
                else if (roll < 78)
                    kind = ROW_CUT_SKIP;
                else if (roll < 85)
                    kind = ROW_CUT_COUNT;
                else if (roll < 92)
                    kind = ROW_CUT_RUN;
                else
                    kind = ROW_NOISE;
                send_row(kind);
                // occasionally let the decoder run completely dry mid-phase
                if (!quiet && $urandom_range(0, 39) == 0)
                    drain_decoder();
            end
        end

        drain_decoder();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("PASS sprite_rle_row_decoder");
        else
            $display("FAIL sprite_rle_row_decoder");
        $finish;
    end

endmodule

// File: sprite_rle_row_decoder.f
rtl/srd_pkg.sv
rtl/sprite_rle_row_decoder.sv
verif/srd_row_checker.sv
verif/tb.sv
